[src/primality_trial_division_defines.svh]
// Assertion macros shared by the primality block.
`ifndef PRIMALITY_TRIAL_DIVISION_DEFINES_SVH
`define PRIMALITY_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ptd_pkg.sv]
`timescale 1ns / 1ps

package ptd_pkg;

    // Sequencer state codes
    localparam int unsigned STATE_W = 3;

    localparam logic [STATE_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STATE_W-1:0] ST_RT_MID  = 3'd1;
    localparam logic [STATE_W-1:0] ST_RT_DIV  = 3'd2;
    localparam logic [STATE_W-1:0] ST_RT_EVAL = 3'd3;
    localparam logic [STATE_W-1:0] ST_TD_NEXT = 3'd4;
    localparam logic [STATE_W-1:0] ST_TD_DIV  = 3'd5;
    localparam logic [STATE_W-1:0] ST_TD_EVAL = 3'd6;
    localparam logic [STATE_W-1:0] ST_FINISH  = 3'd7;

    // Result channel: one flag padded to a byte
    localparam int unsigned OUT_TDATA_W = 8;

endpackage

[src/primality_trial_division.sv]
`timescale 1ns / 1ps
// Channel   Direction  Ports                      Content
// s_axis    in         s_tvalid s_tready s_tdata  number (DATA_WIDTH bits, signed)
// m_axis    out        m_tvalid m_tready m_tdata  is_prime (1 bit)
//
// One item at a time through a shared bit-serial restoring divider, one
// quotient bit a cycle. Root search: about DATA_WIDTH - 2 division steps;
// trial division: up to root - 1 steps, about 46341 steps worst case at
// DATA_WIDTH = 32. Negative, zero and one skip the divider and finish as
// not prime. s_tready is high only while idle; a finished result waits in
// the output register, so the next item is taken while m_tready is low.
// Reset clears the sequencer and output valid.

`include "primality_trial_division_defines.svh"

module primality_trial_division #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata fields from bit 0: number [DATA_WIDTH-1:0], zero pad to bytes
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata fields from bit 0: is_prime [0], zero pad [7:1]
    output logic [ptd_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready
);

    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

    logic [ptd_pkg::STATE_W-1:0] state_reg, state_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_bit_reg, out_bit_next;
    logic                        result_reg, result_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [W-1:0]                m_reg, m_next;
    logic [W-1:0]                lo_reg, lo_next;
    logic [W-1:0]                hi_reg, hi_next;
    logic [W-1:0]                best_reg, best_next;
    logic [W-1:0]                dv_reg, dv_next;
    logic [W-1:0]                rem_reg, rem_next;
    logic [W-1:0]                quo_reg, quo_next;

    logic [W-1:0] number;
    logic         in_fire;
    logic         out_free;
    logic [W-1:0] mid;
    logic [W:0]   rem_shift;
    logic [W:0]   rem_diff;

    assign number   = s_tdata[W-1:0];
    assign s_tready = (state_reg == ptd_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ptd_pkg::OUT_TDATA_W - 1){1'b0}}, out_bit_reg};

    // Midpoint of the root search interval, no overflow
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // One restoring division step
    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, dv_reg};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        result_next    = result_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        best_next      = best_reg;
        dv_next        = dv_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;

        // Drop a delivered result
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    m_next = number;
                    if (number[W-1] || (number <= W'(1)))
                    begin
                        result_next = 1'b0;
                        state_next  = ptd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        lo_next    = W'(1);
                        hi_next    = number >> 1;
                        best_next  = W'(1);
                        state_next = ptd_pkg::ST_RT_MID;
                    end
                end
            end

            ptd_pkg::ST_RT_MID:
            begin
                if (lo_reg <= hi_reg)
                begin
                    // Start m / mid
                    dv_next    = mid;
                    rem_next   = '0;
                    quo_next   = m_reg;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = ptd_pkg::ST_RT_DIV;
                end
                else
                begin
                    // Root found in best_reg; first divisor is two
                    dv_next    = W'(2);
                    state_next = ptd_pkg::ST_TD_NEXT;
                end
            end

            ptd_pkg::ST_RT_DIV,
            ptd_pkg::ST_TD_DIV:
            begin
                if (!rem_diff[W])
                begin
                    rem_next = rem_diff[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = (state_reg == ptd_pkg::ST_RT_DIV) ?
                                 ptd_pkg::ST_RT_EVAL : ptd_pkg::ST_TD_EVAL;
                end
            end

            ptd_pkg::ST_RT_EVAL:
            begin
                // Accept mid when mid <= m / mid
                if (dv_reg <= quo_reg)
                begin
                    best_next = dv_reg;
                    lo_next   = dv_reg + W'(1);
                end
                else
                begin
                    hi_next = dv_reg - W'(1);
                end
                state_next = ptd_pkg::ST_RT_MID;
            end

            ptd_pkg::ST_TD_NEXT:
            begin
                if (dv_reg > best_reg)
                begin
                    result_next = 1'b1;
                    state_next  = ptd_pkg::ST_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = m_reg;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = ptd_pkg::ST_TD_DIV;
                end
            end

            ptd_pkg::ST_TD_EVAL:
            begin
                if (rem_reg == '0)
                begin
                    result_next = 1'b0;
                    state_next  = ptd_pkg::ST_FINISH;
                end
                else
                begin
                    dv_next    = dv_reg + W'(1);
                    state_next = ptd_pkg::ST_TD_NEXT;
                end
            end

            ptd_pkg::ST_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = result_reg;
                    state_next     = ptd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_bit_reg <= out_bit_next;
        result_reg  <= result_next;
        cnt_reg     <= cnt_next;
        m_reg       <= m_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        best_reg    <= best_next;
        dv_reg      <= dv_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    // Checks
    `PTD_ASSERT_SAME(a_divisor_nonzero, (state_reg == ptd_pkg::ST_RT_DIV) || (state_reg == ptd_pkg::ST_TD_DIV), dv_reg != '0, "divider running with zero divisor")
    `PTD_ASSERT_NEXT(a_negative_short, in_fire && number[W-1], (state_reg == ptd_pkg::ST_FINISH) && !result_reg, "negative input not rejected at once")
    `PTD_ASSERT_NEXT(a_finish_holds, (state_reg == ptd_pkg::ST_FINISH) && out_valid_reg && !m_tready, state_reg == ptd_pkg::ST_FINISH, "result overwrote a pending item")
    `PTD_ASSERT_SAME(a_trial_bound, state_reg == ptd_pkg::ST_TD_DIV, (dv_reg >= W'(2)) && (dv_reg <= best_reg), "trial divisor outside two to root")

endmodule
